// ===== rtl/core/lsa_pkg.sv =====
// ----------------------------------------------------------------------------
// lsa_pkg
// shared widths, constants and controller/datapath handshake structs
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int SLOT_W      = 6;
  localparam int LIFE_W      = 16;
  localparam int DT_W        = 16;
  localparam int RATE_W      = 16;
  localparam int DECAY_SHIFT = 9;
  localparam int PROD_W      = RATE_W + DT_W;
  localparam int DEC_W       = PROD_W - DECAY_SHIFT;

  localparam logic [LIFE_W-1:0] LIFE_FULL  = 16'h8000;
  localparam logic [LIFE_W-1:0] LIFE_EMPTY = 16'h0000;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef struct packed {
    logic clr;        // clearing pass write, advance count
    logic start;      // accept item, set up scan
    logic issue;      // issue one store read, advance pointer
    logic take;       // latch hit slot
    logic take_full;  // latch pool-full result
    logic commit;     // write full life, load output register
  } lsa_cmd_t;

  typedef struct packed {
    logic cnt_done;
    logic pvld;
    logic hit;
    logic mode_alloc;
    logic out_free;
  } lsa_stat_t;

endpackage

// ===== rtl/core/lsa_if.sv =====
// ----------------------------------------------------------------------------
// lsa interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface lsa_in_if
  import lsa_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            action;
  logic [DT_W-1:0] delta_time;

  modport source (output valid, output action, output delta_time, input ready);
  modport sink   (input valid, input action, input delta_time, output ready);
endinterface

interface lsa_out_if
  import lsa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic              was_full;

  modport source (output valid, output slot, output was_full, input ready);
  modport sink   (input valid, input slot, input was_full, output ready);
endinterface

// ===== rtl/core/lsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsa_ctrl
// sequencer for clearing pass, tick scan and next-fit allocate scan
// ----------------------------------------------------------------------------
module lsa_ctrl
  import lsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lsa_stat_t stat,
  output lsa_cmd_t  cmd
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.cnt_done) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.clr = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.mode_alloc) begin
          if (stat.hit) begin
            cmd.take  = 1'b1;
            state_nxt = ST_COMMIT;
          end else if (stat.cnt_done && !stat.pvld) begin
            cmd.take_full = 1'b1;
            state_nxt     = ST_COMMIT;
          end else begin
            cmd.issue = !stat.cnt_done;
          end
        end else begin
          if (stat.cnt_done && !stat.pvld) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.issue = !stat.cnt_done;
          end
        end
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/lsa_datapath.sv =====
// ----------------------------------------------------------------------------
// lsa_datapath
// life store, scan pointer, decay multiplier and result register
// ----------------------------------------------------------------------------
module lsa_datapath
  import lsa_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lsa_cmd_t          cmd,
  output lsa_stat_t         stat,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata,
  input  logic              in_action,
  input  logic [DT_W-1:0]   in_delta_time,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_was_full
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  logic [LIFE_W-1:0] mem [SLOT_COUNT];
  logic [LIFE_W-1:0] rdata_r;

  logic [IDX_W-1:0]  addr_r;
  logic [IDX_W-1:0]  addr_inc;
  logic [CNT_W-1:0]  cnt_r;
  logic              pvld_r;
  logic [IDX_W-1:0]  paddr_r;
  logic              mode_r;
  logic [DEC_W-1:0]  dec_r;
  logic [IDX_W-1:0]  next_r;
  logic [IDX_W-1:0]  found_r;
  logic              full_r;
  logic [RATE_W-1:0] decay_r;
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_full_r;

  logic [PROD_W-1:0] prod;
  logic [LIFE_W-1:0] aged;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LIFE_W-1:0] mem_wdata;
  logic              out_free;

  assign prod     = decay_r * in_delta_time;
  assign addr_inc = (addr_r == IDX_W'(SLOT_COUNT - 1)) ? '0 : addr_r + 1'b1;
  assign out_free = !out_valid_r || out_ready;

  // saturating decay, free slots stay at zero
  always_comb begin
    if (DEC_W'(rdata_r) <= dec_r) begin
      aged = LIFE_EMPTY;
    end else begin
      aged = rdata_r - dec_r[LIFE_W-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = paddr_r;
    mem_wdata = aged;
    priority if (cmd.clr) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r[IDX_W-1:0];
      mem_wdata = LIFE_EMPTY;
    end else if (cmd.commit) begin
      mem_we    = 1'b1;
      mem_waddr = found_r;
      mem_wdata = LIFE_FULL;
    end else if (pvld_r && (mode_r == ACT_TICK)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      cnt_r       <= '0;
      pvld_r      <= 1'b0;
      mode_r      <= ACT_TICK;
      next_r      <= '0;
      decay_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        decay_r <= cfg_wdata;
      end
      pvld_r <= cmd.issue;
      if (cmd.clr) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.start) begin
        mode_r <= in_action;
        addr_r <= (in_action == ACT_ALLOC) ? next_r : '0;
        cnt_r  <= '0;
      end
      if (cmd.issue) begin
        addr_r <= addr_inc;
        cnt_r  <= cnt_r + 1'b1;
      end
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (!full_r) begin
          next_r <= found_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dec_r <= prod[PROD_W-1:DECAY_SHIFT];
    end
    if (cmd.issue) begin
      paddr_r <= addr_r;
    end
    if (cmd.take) begin
      found_r <= paddr_r;
      full_r  <= 1'b0;
    end
    if (cmd.take_full) begin
      found_r <= '0;
      full_r  <= 1'b1;
    end
    if (cmd.commit) begin
      out_slot_r <= SLOT_W'(found_r);
      out_full_r <= full_r;
    end
  end

  assign stat.cnt_done   = (cnt_r == CNT_W'(SLOT_COUNT));
  assign stat.pvld       = pvld_r;
  assign stat.hit        = pvld_r && (mode_r == ACT_ALLOC) && (rdata_r == LIFE_EMPTY);
  assign stat.mode_alloc = (mode_r == ACT_ALLOC);
  assign stat.out_free   = out_free;

  assign out_valid    = out_valid_r;
  assign out_slot     = out_slot_r;
  assign out_was_full = out_full_r;

endmodule

// ===== rtl/core/lifetime_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// lifetime_slot_allocator
// pool of lifetime slots with per-tick decay and next-fit allocation
// ----------------------------------------------------------------------------
// a tick item gives no result
// an allocate item puts its slot, or the pool-full flag, into the output register at commit
// throughput: one item at a time, set by the sequential scan of the life store
// a new item is taken while a result still waits in the output register
// reset: a clearing pass writes every slot free,
//   items are held off meanwhile, configuration writes are taken at once
module lifetime_slot_allocator
  import lsa_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  lsa_in_if.sink            in_ch,
  lsa_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata
);

  // command and status between sequencer and datapath
  lsa_cmd_t  cmd;
  lsa_stat_t stat;

  // sequencer: clear pass, then idle / scan per item, with a commit for allocate items
  lsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // life store with pipelined read-modify-write scan and result register
  lsa_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_action     (in_ch.action),
    .in_delta_time (in_ch.delta_time),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_slot      (out_ch.slot),
    .out_was_full  (out_ch.was_full)
  );

endmodule
